// File: sv/stop_and_wait_frame_receiver_core_assert.svh
// assertion helpers used by the receiver controller
`ifndef STOP_AND_WAIT_FRAME_RECEIVER_CORE_ASSERT_SVH
`define STOP_AND_WAIT_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int MAX_DATA_DEF = 16;

   localparam logic [7:0] CTRL_SEQ_ZERO = 8'h00;
   localparam logic [7:0] CTRL_SEQ_ONE  = 8'h02;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_ZERO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_ONE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REJ_ZERO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REJ_ONE   = 3'd6;

   localparam logic [7:0] FLAG_RST     = 8'd126;
   localparam logic [7:0] ADDRESS_RST  = 8'd3;
   localparam logic [7:0] DISC_RST     = 8'd11;
   localparam logic [7:0] RR_ZERO_RST  = 8'd5;
   localparam logic [7:0] RR_ONE_RST   = 8'd133;
   localparam logic [7:0] REJ_ZERO_RST = 8'd1;
   localparam logic [7:0] REJ_ONE_RST  = 8'd129;

   localparam logic [1:0] KIND_RESPONSE = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_DISC     = 2'd2;

   // positions inside a supervision frame
   localparam int SUP_IDX_W = 3;
   localparam logic [SUP_IDX_W-1:0] SUP_OPEN  = 3'd0;
   localparam logic [SUP_IDX_W-1:0] SUP_ADDR  = 3'd1;
   localparam logic [SUP_IDX_W-1:0] SUP_CODE  = 3'd2;
   localparam logic [SUP_IDX_W-1:0] SUP_CHECK = 3'd3;
   localparam logic [SUP_IDX_W-1:0] SUP_CLOSE = 3'd4;

   typedef enum logic [8:0] {
      H_FLAG  = 9'b000000001,
      H_ADDR  = 9'b000000010,
      H_CTRL  = 9'b000000100,
      H_HCHK  = 9'b000001000,
      H_BODY0 = 9'b000010000,
      H_BODY1 = 9'b000100000,
      H_BODY  = 9'b001000000,
      H_DCHK  = 9'b010000000,
      H_DFLAG = 9'b100000000
   } hunt_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SUP  = 4'b0010,
      S_DATA = 4'b0100,
      S_DISC = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic accept_en;
      logic emit_sup;
      logic emit_data;
      logic emit_disc;
      logic last;
   } sfr_cmd_type;

   typedef struct packed {
      logic accepted;
      logic ev_close;
      logic ev_disc;
      logic slot_free;
      logic sup_done;
      logic deliver;
      logic data_last;
   } sfr_sts_type;

endpackage

// File: sv/sfr_if.sv
`timescale 1ns / 1ps

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;
   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

interface sfr_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/sfr_datapath.sv
`timescale 1ns / 1ps

module sfr_datapath
   import sfr_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sfr_req_if.sink       req_bus,
   sfr_rsp_if.source     rsp_bus,
   sfr_csr_if.sink       csr_bus,
   input  sfr_cmd_type   cmd,
   output sfr_sts_type   sts
);

   localparam int DEPTH = MAX_DATA + 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   // configuration
   logic [7:0] flag_ff, addr_ff, disc_ff, rr0_ff, rr1_ff, rej0_ff, rej1_ff;

   // frame parser
   hunt_type         hunt_ff, hunt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic             seq_seen_ff, seq_seen_in;
   logic             exp_seq_ff, exp_seq_in;
   logic [7:0]       code_ff, code_in;
   logic             deliver_ff, deliver_in;

   // result sequencing
   logic [SUP_IDX_W-1:0] sup_idx_ff, sup_idx_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [7:0]           rd_data_ff;
   logic [7:0]           store_mem [DEPTH];

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_value_ff, rsp_value_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       accepted;
   logic       wr_en;
   logic       close_hit;
   logic       disc_hit;
   logic       store_hit;
   logic [7:0] rx;
   logic [7:0] hdr_chk;
   logic [7:0] sup_byte;
   logic       emit_any;

   assign rx       = req_bus.rx_byte;
   assign accepted = req_bus.valid && cmd.accept_en;
   assign hdr_chk  = addr_ff ^ {6'b0, seq_seen_ff, 1'b0};

   assign req_bus.ready = cmd.accept_en;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      hunt_in     = hunt_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      seq_seen_in = seq_seen_ff;
      exp_seq_in  = exp_seq_ff;
      code_in     = code_ff;
      deliver_in  = deliver_ff;
      wr_en       = 1'b0;
      close_hit   = 1'b0;
      disc_hit    = 1'b0;
      store_hit   = 1'b0;
      if (accepted) begin
         case (hunt_ff)
            H_FLAG: begin
               if (rx == flag_ff) hunt_in = H_ADDR;
            end
            H_ADDR: begin
               if (rx == addr_ff) hunt_in = H_CTRL;
               else if (rx != flag_ff) hunt_in = H_FLAG;
            end
            H_CTRL: begin
               if (rx == CTRL_SEQ_ONE || rx == CTRL_SEQ_ZERO) begin
                  seq_seen_in = rx[1];
                  hunt_in     = H_HCHK;
               end else if (rx == flag_ff) begin
                  hunt_in = H_ADDR;
               end else if (rx == disc_ff) begin
                  hunt_in = H_DCHK;
               end else begin
                  hunt_in = H_FLAG;
               end
            end
            H_HCHK: begin
               if (rx == hdr_chk) begin
                  hunt_in  = H_BODY0;
                  count_in = '0;
                  xor_in   = '0;
               end else if (rx == flag_ff) begin
                  hunt_in = H_ADDR;
               end else begin
                  hunt_in = H_FLAG;
               end
            end
            H_BODY0, H_BODY1: begin
               if (rx == flag_ff) hunt_in = H_ADDR;
               else store_hit = 1'b1;
            end
            H_BODY: begin
               if (rx == flag_ff) close_hit = 1'b1;
               else store_hit = 1'b1;
            end
            H_DCHK: begin
               if (rx == (addr_ff ^ disc_ff)) hunt_in = H_DFLAG;
               else if (rx == flag_ff) hunt_in = H_ADDR;
               else hunt_in = H_FLAG;
            end
            H_DFLAG: begin
               disc_hit = (rx == flag_ff);
               hunt_in  = H_FLAG;
            end
            default: begin
               hunt_in = H_FLAG;
            end
         endcase

         if (store_hit) begin
            // a body byte with the store full drops the frame
            if (count_ff >= CNT_W'(DEPTH)) begin
               hunt_in = H_FLAG;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               xor_in   = xor_ff ^ rx;
               if (hunt_ff == H_BODY0) hunt_in = H_BODY1;
               else if (hunt_ff == H_BODY1) hunt_in = H_BODY;
            end
         end

         if (close_hit) begin
            hunt_in    = H_FLAG;
            deliver_in = 1'b0;
            if (seq_seen_ff != exp_seq_ff) begin
               code_in = exp_seq_ff ? rr1_ff : rr0_ff;
            end else if (xor_ff != 8'd0) begin
               code_in = exp_seq_ff ? rej1_ff : rej0_ff;
            end else begin
               code_in    = exp_seq_ff ? rr0_ff : rr1_ff;
               exp_seq_in = !exp_seq_ff;
               deliver_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      case (sup_idx_ff)
         SUP_OPEN:  sup_byte = flag_ff;
         SUP_ADDR:  sup_byte = addr_ff;
         SUP_CODE:  sup_byte = code_ff;
         SUP_CHECK: sup_byte = addr_ff ^ code_ff;
         SUP_CLOSE: sup_byte = flag_ff;
         default:   sup_byte = flag_ff;
      endcase
   end

   always_comb begin
      sup_idx_in = sup_idx_ff;
      rd_idx_in  = rd_idx_ff;
      if (close_hit) begin
         sup_idx_in = SUP_OPEN;
         rd_idx_in  = '0;
      end else begin
         if (cmd.emit_sup) sup_idx_in = sup_idx_ff + 1'b1;
         if (cmd.emit_data) rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   assign emit_any = cmd.emit_sup || cmd.emit_data || cmd.emit_disc;

   always_comb begin
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (emit_any) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         if (cmd.emit_sup) begin
            rsp_kind_in  = KIND_RESPONSE;
            rsp_value_in = sup_byte;
         end else if (cmd.emit_data) begin
            rsp_kind_in  = KIND_DATA;
            rsp_value_in = rd_data_ff;
         end else begin
            rsp_kind_in  = KIND_DISC;
            rsp_value_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= FLAG_RST;
         addr_ff      <= ADDRESS_RST;
         disc_ff      <= DISC_RST;
         rr0_ff       <= RR_ZERO_RST;
         rr1_ff       <= RR_ONE_RST;
         rej0_ff      <= REJ_ZERO_RST;
         rej1_ff      <= REJ_ONE_RST;
         hunt_ff      <= H_FLAG;
         count_ff     <= '0;
         xor_ff       <= '0;
         seq_seen_ff  <= 1'b0;
         exp_seq_ff   <= 1'b0;
         deliver_ff   <= 1'b0;
         sup_idx_ff   <= SUP_OPEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_FLAG:     flag_ff <= csr_bus.data;
               CSR_ADDRESS:  addr_ff <= csr_bus.data;
               CSR_DISC:     disc_ff <= csr_bus.data;
               CSR_RR_ZERO:  rr0_ff  <= csr_bus.data;
               CSR_RR_ONE:   rr1_ff  <= csr_bus.data;
               CSR_REJ_ZERO: rej0_ff <= csr_bus.data;
               CSR_REJ_ONE:  rej1_ff <= csr_bus.data;
               default: ;
            endcase
         end
         hunt_ff      <= hunt_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         seq_seen_ff  <= seq_seen_in;
         exp_seq_ff   <= exp_seq_in;
         deliver_ff   <= deliver_in;
         sup_idx_ff   <= sup_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // frame body store, read one entry ahead of the emit pointer
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[count_ff[IDX_W-1:0]] <= rx;
      rd_data_ff <= store_mem[rd_idx_in];
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind  = rsp_kind_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign rsp_bus.last  = rsp_last_ff;

   assign sts.accepted  = accepted;
   assign sts.ev_close  = close_hit;
   assign sts.ev_disc   = disc_hit;
   assign sts.slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign sts.sup_done  = (sup_idx_ff == SUP_CLOSE);
   assign sts.deliver   = deliver_ff;
   assign sts.data_last = ((CNT_W'(rd_idx_ff) + CNT_W'(2)) == count_ff);

endmodule

// File: sv/sfr_ctrl.sv
`timescale 1ns / 1ps

`include "stop_and_wait_frame_receiver_core_assert.svh"

module sfr_ctrl
   import sfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  sfr_sts_type sts,
   output sfr_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept_en = 1'b1;
            if (sts.ev_close) state_in = S_SUP;
            else if (sts.ev_disc) state_in = S_DISC;
         end
         S_SUP: begin
            if (sts.slot_free) begin
               cmd.emit_sup = 1'b1;
               if (sts.sup_done) begin
                  cmd.last = !sts.deliver;
                  state_in = sts.deliver ? S_DATA : S_IDLE;
               end
            end
         end
         S_DATA: begin
            if (sts.slot_free) begin
               cmd.emit_data = 1'b1;
               cmd.last      = sts.data_last;
               if (sts.data_last) state_in = S_IDLE;
            end
         end
         S_DISC: begin
            if (sts.slot_free) begin
               cmd.emit_disc = 1'b1;
               cmd.last      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFR_ASSERT_IMP(a_emit_has_slot, clock, reset, (cmd.emit_sup || cmd.emit_data || cmd.emit_disc), sts.slot_free, "result emitted into a full output register")
   `SFR_ASSERT_NEXT(a_close_starts_sup, clock, reset, sts.ev_close, (state_ff == S_SUP), "frame close did not start the response")
   `SFR_ASSERT_NEXT(a_disc_single, clock, reset, (state_ff == S_DISC && sts.slot_free), (state_ff == S_IDLE), "disconnect report not single")
   `SFR_ASSERT_IMP(a_last_with_emit, clock, reset, cmd.last, (cmd.emit_sup || cmd.emit_data || cmd.emit_disc), "last flagged without a result")

endmodule

// File: sv/stop_and_wait_frame_receiver_core.sv
`timescale 1ns / 1ps

// Stop-and-wait frame receiver.
// req_bus carries received link bytes, one per transaction. rsp_bus carries
// results: response bytes to transmit (kind 0), delivered data bytes (kind 1)
// and disconnect reports (kind 2); last marks the final result of one byte.
// csr_bus writes the seven code registers by index; the user must write them
// only while idle, as the block does not enforce it. A byte that causes no
// result is taken and ready stays high. A closing flag is taken, then the
// five response bytes and the data bytes of a good frame leave one per cycle
// while rsp_bus does not stall, the first after the controller state and the
// output register are set; the input is held until the last result is emitted.
// A disconnect report leaves after the controller state and output register.
// When rsp_bus stalls, the pending result holds and the sequencer waits;
// input is taken again once the last result of the byte is in the output
// register.
// Reset restores the code registers to their defaults, resumes flag hunting
// and expects sequence zero; the body store is not cleared.
module stop_and_wait_frame_receiver_core
   import sfr_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_bus,
   sfr_rsp_if.source rsp_bus,
   sfr_csr_if.sink   csr_bus
);

   sfr_cmd_type cmd;
   sfr_sts_type sts;

   sfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   sfr_datapath #(
      .MAX_DATA (MAX_DATA)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

endmodule
